FILE: hdl/tcc_pkg.sv
// Shared constants and types for the text console with cursor and scroll.
package tcc_pkg;

    // Screen geometry and tab spacing.
    localparam int COLUMNS  = 32;
    localparam int ROWS     = 24;
    localparam int TAB_STOP = 4;

    // Port field widths.
    localparam int OP_W    = 1;
    localparam int CH_W    = 8;
    localparam int COL_W   = 6;
    localparam int ROW_W   = 5;
    localparam int PROW_W  = 5;
    localparam int PCOL_W  = 5;

    // Cell store geometry.
    localparam int DEPTH      = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CELL_COL_W = $clog2(COLUMNS);
    localparam int PHYS_ROW_W = $clog2(ROWS);

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUT     = 1'b0;
    localparam logic [OP_W-1:0] OP_SET_COL = 1'b1;

    // Control character codes.
    localparam logic [CH_W-1:0] CODE_TAB = 8'd9;
    localparam logic [CH_W-1:0] CODE_NL  = 8'd10;
    localparam logic [CH_W-1:0] CODE_CR  = 8'd13;

    // A cell named by its row on screen and its column.
    typedef struct packed {
        logic [ROW_W-1:0]      row;
        logic [CELL_COL_W-1:0] col;
    } t_cell_ref;

endpackage

FILE: hdl/text_console_cursor_scroll.sv
// Top level of the text console: sequencer, cursor state and cell store.
//
// A character console of ROWS x COLUMNS cells held in one RAM used as a circular
// buffer of rows, so scrolling moves only a top-row pointer. After reset the
// block sweeps the store to zero, one cell per cycle, before it takes the first
// transfer. A put that stores a character passes through the write, peek and
// wait states before its result is loaded into the output register; a tab or
// carriage return that starts no new row, or a set-column step, goes straight to
// peek and wait. A step that starts a new row (newline, pending wrap, or scroll)
// first clears the landing row through the single RAM port. One item is handled
// at a time; the next input transfer is taken while a finished result still
// waits in the output register.
module text_console_cursor_scroll import tcc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [CH_W-1:0]   i_char_code,
    input  logic [COL_W-1:0]  i_new_column,
    input  logic [PROW_W-1:0] i_peek_row,
    input  logic [PCOL_W-1:0] i_peek_col,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [COL_W-1:0]  o_cursor_col,
    output logic [ROW_W-1:0]  o_cursor_row,
    output logic              o_scrolled,
    output logic [CH_W-1:0]   o_peek_char
);

    localparam logic [2:0] ST_SWEEP = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CLR   = 3'd2;
    localparam logic [2:0] ST_WRITE = 3'd3;
    localparam logic [2:0] ST_PEEK  = 3'd4;
    localparam logic [2:0] ST_WAIT  = 3'd5;

    logic [2:0]            r_state, n_state;
    logic [ADDR_W-1:0]     r_cnt, n_cnt;
    logic [COL_W-1:0]      r_col, n_col;
    logic [ROW_W-1:0]      r_row, n_row;
    logic [PHYS_ROW_W-1:0] r_top, n_top;
    logic [CELL_COL_W-1:0] r_wcol, n_wcol;
    logic [CH_W-1:0]       r_code, n_code;
    logic                  r_do_write, n_do_write;
    logic                  r_scr, n_scr;
    logic [PROW_W-1:0]     r_peek_row, n_peek_row;
    logic [PCOL_W-1:0]     r_peek_col, n_peek_col;
    logic                  r_peek_ok, n_peek_ok;

    logic                  r_out_valid, n_out_valid;
    logic [COL_W-1:0]      r_out_col, n_out_col;
    logic [ROW_W-1:0]      r_out_row, n_out_row;
    logic                  r_out_scr, n_out_scr;
    logic [CH_W-1:0]       r_out_char, n_out_char;

    t_cell_ref             cell_ref;
    logic [ADDR_W-1:0]     unit_addr;
    logic [ADDR_W-1:0]     ram_addr;
    logic                  ram_we;
    logic [CH_W-1:0]       ram_wdata;
    logic [CH_W-1:0]       ram_rdata;
    logic                  accept;
    logic                  out_load;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_load   = (r_state == ST_WAIT) && (!r_out_valid || i_out_ready);

    // Pick the cell that the shared address unit works on this cycle.
    always_comb begin
        case (r_state)
            ST_CLR: begin
                cell_ref.row = r_row;
                cell_ref.col = r_cnt[CELL_COL_W-1:0];
            end
            ST_WRITE: begin
                cell_ref.row = r_row;
                cell_ref.col = r_wcol;
            end
            default: begin
                cell_ref.row = ROW_W'(r_peek_row);
                cell_ref.col = CELL_COL_W'(r_peek_col);
            end
        endcase
    end

    tcc_addr_unit u_addr (
        .i_ref  (cell_ref),
        .i_top  (r_top),
        .o_addr (unit_addr)
    );

    // The reset sweep walks the store linearly; everything else goes through the unit.
    assign ram_addr  = (r_state == ST_SWEEP) ? r_cnt : unit_addr;
    assign ram_we    = (r_state == ST_SWEEP) || (r_state == ST_CLR) || (r_state == ST_WRITE);
    assign ram_wdata = (r_state == ST_WRITE) ? r_code : '0;

    tcc_ram #(
        .WIDTH (CH_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Sequencer and cursor update.
    always_comb begin
        logic              wrap;
        logic              new_row;
        logic [COL_W-1:0]  col_start;
        logic [COL_W:0]    tab_col;

        n_state    = r_state;
        n_cnt      = r_cnt;
        n_col      = r_col;
        n_row      = r_row;
        n_top      = r_top;
        n_wcol     = r_wcol;
        n_code     = r_code;
        n_do_write = r_do_write;
        n_scr      = r_scr;
        n_peek_row = r_peek_row;
        n_peek_col = r_peek_col;
        n_peek_ok  = r_peek_ok;

        wrap      = (r_col >= COL_W'(COLUMNS)) && (i_char_code != CODE_NL);
        new_row   = wrap || (i_char_code == CODE_NL);
        col_start = wrap ? '0 : r_col;
        tab_col   = (COL_W + 1)'((col_start / TAB_STOP + 1) * TAB_STOP);

        case (r_state)
            ST_SWEEP: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == ADDR_W'(DEPTH - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_peek_row = i_peek_row;
                    n_peek_col = i_peek_col;
                    n_peek_ok  = ({1'b0, i_peek_row} < (PROW_W + 1)'(ROWS)) &&
                                 ({1'b0, i_peek_col} < (PCOL_W + 1)'(COLUMNS));
                    n_scr      = 1'b0;
                    n_do_write = 1'b0;
                    n_code     = i_char_code;
                    n_cnt      = '0;
                    n_state    = ST_PEEK;
                    if (i_operation == OP_SET_COL) begin
                        // Step back one row, stopping at the top.
                        if (r_row != '0) begin
                            n_row = r_row - 1'b1;
                        end
                        n_col = (i_new_column > COL_W'(COLUMNS)) ? COL_W'(COLUMNS)
                                                                  : i_new_column;
                    end else begin
                        // Column update for the put.
                        if (i_char_code == CODE_TAB) begin
                            n_col = (tab_col > (COL_W + 1)'(COLUMNS)) ? COL_W'(COLUMNS)
                                                                       : COL_W'(tab_col);
                        end else if (i_char_code == CODE_NL || i_char_code == CODE_CR) begin
                            n_col = '0;
                        end else begin
                            n_wcol     = CELL_COL_W'(col_start);
                            n_col      = col_start + 1'b1;
                            n_do_write = 1'b1;
                            n_state    = ST_WRITE;
                        end
                        // Move down one row, or scroll by advancing the top pointer.
                        if (new_row) begin
                            if (r_row >= ROW_W'(ROWS - 1)) begin
                                n_scr = 1'b1;
                                n_top = (r_top == PHYS_ROW_W'(ROWS - 1)) ? '0
                                                                          : r_top + 1'b1;
                            end else begin
                                n_row = r_row + 1'b1;
                            end
                            n_state = ST_CLR;
                        end
                    end
                end
            end
            ST_CLR: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == ADDR_W'(COLUMNS - 1)) begin
                    n_cnt   = '0;
                    n_state = r_do_write ? ST_WRITE : ST_PEEK;
                end
            end
            ST_WRITE: begin
                n_state = ST_PEEK;
            end
            ST_PEEK: begin
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output register: loaded from the read-back, emptied by a result transfer.
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_col   = r_out_col;
        n_out_row   = r_out_row;
        n_out_scr   = r_out_scr;
        n_out_char  = r_out_char;
        if (out_load) begin
            n_out_valid = 1'b1;
            n_out_col   = r_col;
            n_out_row   = r_row;
            n_out_scr   = r_scr;
            n_out_char  = r_peek_ok ? ram_rdata : '0;
        end
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_cnt       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_top       <= '0;
            r_do_write  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_col       <= n_col;
            r_row       <= n_row;
            r_top       <= n_top;
            r_do_write  <= n_do_write;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_wcol     <= n_wcol;
        r_code     <= n_code;
        r_scr      <= n_scr;
        r_peek_row <= n_peek_row;
        r_peek_col <= n_peek_col;
        r_peek_ok  <= n_peek_ok;
        r_out_col  <= n_out_col;
        r_out_row  <= n_out_row;
        r_out_scr  <= n_out_scr;
        r_out_char <= n_out_char;
    end

    assign o_out_valid  = r_out_valid;
    assign o_cursor_col = r_out_col;
    assign o_cursor_row = r_out_row;
    assign o_scrolled   = r_out_scr;
    assign o_peek_char  = r_out_char;

endmodule

FILE: hdl/tcc_ram.sv
// Generic single-port RAM with registered read data.
module tcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write when enabled; the read returns the old contents from a register in the next cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/tcc_addr_unit.sv
// Shared address unit: maps a screen row and column onto the circular cell store.
module tcc_addr_unit import tcc_pkg::*; (
    input  t_cell_ref             i_ref,
    input  logic [PHYS_ROW_W-1:0] i_top,
    output logic [ADDR_W-1:0]     o_addr
);

    logic [ROW_W:0]        sum;
    logic [PHYS_ROW_W-1:0] phys;

    // The screen row is offset by the physical row that holds the top line.
    always_comb begin
        sum = {1'b0, i_ref.row} + (ROW_W + 1)'(i_top);
        if (sum >= (ROW_W + 1)'(ROWS)) begin
            phys = PHYS_ROW_W'(sum - (ROW_W + 1)'(ROWS));
        end else begin
            phys = PHYS_ROW_W'(sum);
        end
        o_addr = ADDR_W'(phys * COLUMNS) + ADDR_W'(i_ref.col);
    end

endmodule

FILE: hdl/tcc_checker.sv
// Port-level checks for the text console, bound to the top level.
module tcc_checker import tcc_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [COL_W-1:0]  o_cursor_col,
    input logic [ROW_W-1:0]  o_cursor_row,
    input logic              o_scrolled,
    input logic [CH_W-1:0]   o_peek_char
);

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // An input transfer starts work, so the block is busy in the next cycle.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after an input transfer");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_cursor_col) &&
        $stable(o_cursor_row) && $stable(o_scrolled) && $stable(o_peek_char))
        else $error("stalled result changed");

    // The cursor stays on screen.
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_cursor_col <= COL_W'(COLUMNS)) &&
        (o_cursor_row <= ROW_W'(ROWS - 1)))
        else $error("cursor out of range");

    // A scroll leaves the cursor on the bottom row.
    a_scroll_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_scrolled |-> o_cursor_row == ROW_W'(ROWS - 1))
        else $error("scroll reported away from the bottom row");

endmodule

bind text_console_cursor_scroll tcc_checker u_tcc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_cursor_col (o_cursor_col),
    .o_cursor_row (o_cursor_row),
    .o_scrolled   (o_scrolled),
    .o_peek_char  (o_peek_char)
);
